/* rtl/icse_pkg.sv */
// Shared types, character codes and keyword tables for the DTSTART extractor.
package icse_pkg;

    typedef enum logic [1:0] {
        PH_IN_LINE,
        PH_AFTER_CR,
        PH_AFTER_CRLF
    } phase_t;

    typedef enum logic [1:0] {
        RG_NAME,
        RG_PARAM,
        RG_VALUE
    } region_t;

    typedef enum logic [1:0] {
        KW_BEGIN,
        KW_END,
        KW_DTSTART
    } kw_t;

    localparam int unsigned DATE_DEPTH = 16;
    localparam int unsigned KW_COUNT   = 3;

    localparam logic [3:0] NAME_SAT   = 4'd8;
    localparam logic [4:0] VALUE_SAT  = 5'd17;
    localparam logic [4:0] VEVENT_LEN = 5'd6;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic        format_ok;
    } dtstart_t;

    function automatic logic [3:0] kw_len(input kw_t kw);
        logic [3:0] len;
        case (kw)
            KW_BEGIN:   len = 4'd5;
            KW_END:     len = 4'd3;
            KW_DTSTART: len = 4'd7;
            default:    len = 4'd0;
        endcase
        return len;
    endfunction

    // Character of a keyword at a position below its length.
    function automatic logic [7:0] kw_char(input kw_t kw, input logic [2:0] pos);
        logic [55:0] txt;
        case (kw)
            KW_BEGIN:   txt = {"BEGIN", 16'h0000};
            KW_END:     txt = {"END", 32'h0000_0000};
            KW_DTSTART: txt = "DTSTART";
            default:    txt = '0;
        endcase
        return txt[55 - 8 * int'(pos) -: 8];
    endfunction

    function automatic logic [7:0] vevent_char(input logic [2:0] pos);
        logic [47:0] txt;
        txt = "VEVENT";
        return (pos < 3'd6) ? txt[47 - 8 * int'(pos) -: 8] : 8'h00;
    endfunction

endpackage

/* rtl/icalendar_event_start_extractor_unit.sv */
// Top level: byte-serial iCalendar line parser emitting DTSTART dates inside VEVENTs.
// Throughput: one text byte per cycle while s_ready is high; every beat updates the parser state.
// A result is registered onto m_valid in the cycle after the beat that closes the line
//   (the byte after CR LF that is not a space, or a stream end right after CR LF).
// The output register frees s_ready as soon as m_ready takes the pending result.
// Reset (aresetn low, synchronous) and a stream end both return the parser to the
//   start of a line outside any event; the value character store is not cleared.
module icalendar_event_start_extractor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_year,
    output logic [6:0]  m_month,
    output logic [6:0]  m_day,
    output logic [6:0]  m_hours,
    output logic [6:0]  m_minutes,
    output logic [6:0]  m_seconds,
    output logic        m_format_ok
);

    // Parser state
    icse_pkg::phase_t  phase_reg, phase_next;
    icse_pkg::region_t region_reg, region_next;
    logic              quote_reg, quote_next;
    logic              bslash_reg, bslash_next;
    logic [2:0]        cand_reg, cand_next;     // live keywords, indexed by kw_t
    logic [3:0]        nlen_reg, nlen_next;
    logic [4:0]        vlen_reg, vlen_next;
    logic              vev_reg, vev_next;
    logic              in_event_reg, in_event_next;
    logic [7:0]        date_reg [icse_pkg::DATE_DEPTH];

    // Result register
    logic               m_valid_reg, m_valid_next;
    icse_pkg::dtstart_t res_reg;
    icse_pkg::dtstart_t dec_res;

    logic accept;
    logic line_end_go;
    logic is_begin, is_end, is_dtstart, vev_full;
    logic in_event_le;
    logic emit;

    // Line state seen by the incoming byte (fresh after a line end)
    icse_pkg::region_t eff_region;
    logic              eff_quote, eff_bslash, eff_vev;
    logic [2:0]        eff_cand;
    logic [3:0]        eff_nlen;
    logic [4:0]        eff_vlen;

    // Result of feeding the byte into the line
    icse_pkg::region_t fd_region;
    logic              fd_quote, fd_bslash, fd_vev, fd_copy;
    logic [2:0]        fd_cand;
    logic [3:0]        fd_nlen;
    logic [4:0]        fd_vlen;
    logic              date_we;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // ---------------- line end: keyword match and event tracking ----------------
    assign line_end_go = (phase_reg == icse_pkg::PH_AFTER_CRLF)
                         && (s_stream_end || (s_text_byte != icse_pkg::CH_SP));

    assign is_begin   = cand_reg[icse_pkg::KW_BEGIN]
                        && (nlen_reg == icse_pkg::kw_len(icse_pkg::KW_BEGIN));
    assign is_end     = cand_reg[icse_pkg::KW_END]
                        && (nlen_reg == icse_pkg::kw_len(icse_pkg::KW_END));
    assign is_dtstart = cand_reg[icse_pkg::KW_DTSTART]
                        && (nlen_reg == icse_pkg::kw_len(icse_pkg::KW_DTSTART));
    assign vev_full   = vev_reg && (vlen_reg == icse_pkg::VEVENT_LEN);

    always_comb begin
        if (is_begin && vev_full) begin
            in_event_le = 1'b1;
        end else if (is_end && vev_full) begin
            in_event_le = 1'b0;
        end else begin
            in_event_le = in_event_reg;
        end
    end

    assign emit = accept && line_end_go && in_event_le && is_dtstart;

    icse_dtstart_decode u_decode (
        .date_chars   (date_reg),
        .value_length (vlen_reg),
        .result       (dec_res)
    );

    // ---------------- byte feed into the current line ----------------
    always_comb begin
        if (line_end_go) begin
            eff_region = icse_pkg::RG_NAME;
            eff_quote  = 1'b0;
            eff_bslash = 1'b0;
            eff_cand   = 3'b111;
            eff_nlen   = 4'd0;
            eff_vlen   = 5'd0;
            eff_vev    = 1'b1;
        end else begin
            eff_region = region_reg;
            eff_quote  = quote_reg;
            eff_bslash = bslash_reg;
            eff_cand   = cand_reg;
            eff_nlen   = nlen_reg;
            eff_vlen   = vlen_reg;
            eff_vev    = vev_reg;
        end
    end

    always_comb begin
        fd_region = eff_region;
        fd_quote  = eff_quote;
        fd_copy   = 1'b1;
        fd_cand   = eff_cand;
        fd_nlen   = eff_nlen;
        fd_vlen   = eff_vlen;
        fd_vev    = eff_vev;

        // Unescaped quote toggles quoting and is still copied.
        if ((s_text_byte == icse_pkg::CH_QUOTE) && !eff_bslash) begin
            fd_quote = !eff_quote;
        end else if (!eff_quote && ((s_text_byte == icse_pkg::CH_SEMI)
                                    || (s_text_byte == icse_pkg::CH_COLON))) begin
            fd_copy = 1'b0;
            if (s_text_byte == icse_pkg::CH_COLON) begin
                fd_region = icse_pkg::RG_VALUE;
            end else if (eff_region == icse_pkg::RG_NAME) begin
                fd_region = icse_pkg::RG_PARAM;
            end
        end
        fd_bslash = (s_text_byte == icse_pkg::CH_BSLASH);

        if (fd_copy && (fd_region == icse_pkg::RG_NAME)) begin
            for (int i = 0; i < icse_pkg::KW_COUNT; i++) begin
                if ((eff_nlen >= icse_pkg::kw_len(icse_pkg::kw_t'(i)))
                    || (s_text_byte != icse_pkg::kw_char(icse_pkg::kw_t'(i),
                                                         eff_nlen[2:0]))) begin
                    fd_cand[i] = 1'b0;
                end
            end
            if (eff_nlen < icse_pkg::NAME_SAT) begin
                fd_nlen = eff_nlen + 4'd1;
            end
        end

        if (fd_copy && (fd_region == icse_pkg::RG_VALUE)) begin
            if ((eff_vlen >= icse_pkg::VEVENT_LEN)
                || (s_text_byte != icse_pkg::vevent_char(eff_vlen[2:0]))) begin
                fd_vev = 1'b0;
            end
            if (eff_vlen < icse_pkg::VALUE_SAT) begin
                fd_vlen = eff_vlen + 5'd1;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        phase_next    = phase_reg;
        region_next   = region_reg;
        quote_next    = quote_reg;
        bslash_next   = bslash_reg;
        cand_next     = cand_reg;
        nlen_next     = nlen_reg;
        vlen_next     = vlen_reg;
        vev_next      = vev_reg;
        in_event_next = in_event_reg;
        date_we       = 1'b0;

        if (accept) begin
            if (s_stream_end) begin
                phase_next    = icse_pkg::PH_IN_LINE;
                region_next   = icse_pkg::RG_NAME;
                quote_next    = 1'b0;
                bslash_next   = 1'b0;
                cand_next     = 3'b111;
                nlen_next     = 4'd0;
                vlen_next     = 5'd0;
                vev_next      = 1'b1;
                in_event_next = 1'b0;
            end else if (phase_reg == icse_pkg::PH_AFTER_CR) begin
                // Byte after CR is taken as LF and dropped.
                phase_next = icse_pkg::PH_AFTER_CRLF;
            end else if ((phase_reg == icse_pkg::PH_AFTER_CRLF)
                         && (s_text_byte == icse_pkg::CH_SP)) begin
                // Folded line: drop the space and keep going.
                phase_next = icse_pkg::PH_IN_LINE;
            end else begin
                in_event_next = in_event_le;
                region_next   = eff_region;
                quote_next    = eff_quote;
                bslash_next   = eff_bslash;
                cand_next     = eff_cand;
                nlen_next     = eff_nlen;
                vlen_next     = eff_vlen;
                vev_next      = eff_vev;
                if (s_text_byte == icse_pkg::CH_CR) begin
                    phase_next = icse_pkg::PH_AFTER_CR;
                end else begin
                    phase_next  = icse_pkg::PH_IN_LINE;
                    region_next = fd_region;
                    quote_next  = fd_quote;
                    bslash_next = fd_bslash;
                    cand_next   = fd_cand;
                    nlen_next   = fd_nlen;
                    vlen_next   = fd_vlen;
                    vev_next    = fd_vev;
                    date_we     = fd_copy && (fd_region == icse_pkg::RG_VALUE)
                                  && (eff_vlen < 5'(icse_pkg::DATE_DEPTH));
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= icse_pkg::PH_IN_LINE;
            region_reg   <= icse_pkg::RG_NAME;
            quote_reg    <= 1'b0;
            bslash_reg   <= 1'b0;
            cand_reg     <= 3'b111;
            nlen_reg     <= 4'd0;
            vlen_reg     <= 5'd0;
            vev_reg      <= 1'b1;
            in_event_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            region_reg   <= region_next;
            quote_reg    <= quote_next;
            bslash_reg   <= bslash_next;
            cand_reg     <= cand_next;
            nlen_reg     <= nlen_next;
            vlen_reg     <= vlen_next;
            vev_reg      <= vev_next;
            in_event_reg <= in_event_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Value characters and result payload: no reset needed.
    always_ff @(posedge aclk) begin
        if (date_we) begin
            date_reg[eff_vlen[3:0]] <= s_text_byte;
        end
        if (emit) begin
            res_reg <= dec_res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_year      = res_reg.year;
    assign m_month     = res_reg.month;
    assign m_day       = res_reg.day;
    assign m_hours     = res_reg.hours;
    assign m_minutes   = res_reg.minutes;
    assign m_seconds   = res_reg.seconds;
    assign m_format_ok = res_reg.format_ok;

    // ---------------- assertions ----------------
    a_stream_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_stream_end) |=> (phase_reg == icse_pkg::PH_IN_LINE)
            && !in_event_reg && (region_reg == icse_pkg::RG_NAME) && (cand_reg == 3'b111))
        else $error("stream end did not reset parser state");

    a_result_only_at_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (phase_reg != icse_pkg::PH_AFTER_CRLF))
            |=> (m_valid_reg == $past(m_valid_reg && !m_ready)))
        else $error("result produced outside a line end");

    a_bad_format_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_format_ok) |-> (m_year == 14'd0) && (m_month == 7'd0)
            && (m_day == 7'd0) && (m_hours == 7'd0) && (m_minutes == 7'd0)
            && (m_seconds == 7'd0))
        else $error("date fields nonzero with format_ok low");

    a_lengths_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (nlen_reg <= icse_pkg::NAME_SAT) && (vlen_reg <= icse_pkg::VALUE_SAT))
        else $error("name or value length beyond saturation");

endmodule

/* rtl/icse_dtstart_decode.sv */
// Turns the first sixteen value characters of a line into DTSTART date fields.
module icse_dtstart_decode (
    input  logic [7:0]       date_chars [icse_pkg::DATE_DEPTH],
    input  logic [4:0]       value_length,
    output icse_pkg::dtstart_t result
);

    logic [icse_pkg::DATE_DEPTH-1:0] is_dig;
    logic [icse_pkg::DATE_DEPTH-1:0] char_ok;
    logic [3:0]                      dval [icse_pkg::DATE_DEPTH];
    logic                            fmt_ok;
    logic [13:0]                     year_val;

    function automatic logic [6:0] two_dig(input logic ok_a, input logic [3:0] a,
                                           input logic ok_b, input logic [3:0] b);
        logic [6:0] v;
        if (!ok_a) begin
            v = 7'd0;
        end else if (!ok_b) begin
            v = 7'(a);
        end else begin
            v = 7'(a) * 7'd10 + 7'(b);
        end
        return v;
    endfunction

    // Characters past the value length never count as digits, so stale data is never used.
    always_comb begin
        for (int p = 0; p < icse_pkg::DATE_DEPTH; p++) begin
            char_ok[p] = value_length > 5'(p);
            is_dig[p]  = char_ok[p] && (date_chars[p] >= icse_pkg::CH_ZERO)
                         && (date_chars[p] <= icse_pkg::CH_NINE);
            dval[p]    = date_chars[p][3:0];
        end
    end

    assign fmt_ok = char_ok[8] && (date_chars[8] == icse_pkg::CH_T)
                    && char_ok[15] && (date_chars[15] == icse_pkg::CH_Z);

    always_comb begin
        if (!is_dig[0]) begin
            year_val = 14'd0;
        end else if (!is_dig[1]) begin
            year_val = 14'(dval[0]);
        end else if (!is_dig[2]) begin
            year_val = 14'(dval[0]) * 14'd10 + 14'(dval[1]);
        end else if (!is_dig[3]) begin
            year_val = 14'(dval[0]) * 14'd100 + 14'(dval[1]) * 14'd10 + 14'(dval[2]);
        end else begin
            year_val = 14'(dval[0]) * 14'd1000 + 14'(dval[1]) * 14'd100
                       + 14'(dval[2]) * 14'd10 + 14'(dval[3]);
        end
    end

    always_comb begin
        result = '0;
        if (fmt_ok) begin
            result.year      = year_val;
            result.month     = two_dig(is_dig[4], dval[4], is_dig[5], dval[5]);
            result.day       = two_dig(is_dig[6], dval[6], is_dig[7], dval[7]);
            result.hours     = two_dig(is_dig[9], dval[9], is_dig[10], dval[10]);
            result.minutes   = two_dig(is_dig[11], dval[11], is_dig[12], dval[12]);
            result.seconds   = two_dig(is_dig[13], dval[13], is_dig[14], dval[14]);
            result.format_ok = 1'b1;
        end
    end

endmodule

/* dv/icalendar_event_start_extractor_unit_test.sv */
// Testbench for the DTSTART extractor: byte stream stimulus, in-line parser model, result check.
`timescale 1ns / 1ps

module icalendar_event_start_extractor_unit_test;

    localparam logic [7:0] CH_LF          = 8'h0A;
    localparam int         WATCHDOG_LIMIT = 2000;
    // Random part stops once at least this many beats have been sent.
    localparam int         RANDOM_BEATS   = 250;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte  = 8'h00;
    logic        s_stream_end = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [13:0] m_year;
    logic [6:0]  m_month;
    logic [6:0]  m_day;
    logic [6:0]  m_hours;
    logic [6:0]  m_minutes;
    logic [6:0]  m_seconds;
    logic        m_format_ok;

    icalendar_event_start_extractor_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_stream_end (s_stream_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_year       (m_year),
        .m_month      (m_month),
        .m_day        (m_day),
        .m_hours      (m_hours),
        .m_minutes    (m_minutes),
        .m_seconds    (m_seconds),
        .m_format_ok  (m_format_ok)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Parser model. Mirrors the unfold / split / keyword tracking of the
    // block and queues one expected date per DTSTART line inside an event.
    // ------------------------------------------------------------------
    icse_pkg::phase_t     fold_phase;
    icse_pkg::region_t    part;
    bit                   in_quotes;
    bit                   after_bslash;
    bit [2:0]             kw_live;          // one bit per kw_t member still matching
    bit [3:0]             name_len;
    bit [4:0]             value_len;
    bit                   value_vevent;     // value still a prefix of VEVENT
    bit [7:0]             value_chars [icse_pkg::DATE_DEPTH];
    bit                   inside_vevent;
    icse_pkg::dtstart_t   dtstart_expected [$];

    int         fail_count;
    bit         idle_on;
    int         beats_sent;
    int         ready_hold;
    int         stuck_cycles;

    function automatic string keyword_text(icse_pkg::kw_t k);
        case (k)
            icse_pkg::KW_BEGIN: return "BEGIN";
            icse_pkg::KW_END:   return "END";
            default:            return "DTSTART";
        endcase
    endfunction

    function automatic void line_clear();
        part         = icse_pkg::RG_NAME;
        in_quotes    = 1'b0;
        after_bslash = 1'b0;
        kw_live      = 3'b111;
        name_len     = '0;
        value_len    = '0;
        value_vevent = 1'b1;
    endfunction

    function automatic void parser_reset();
        fold_phase    = icse_pkg::PH_IN_LINE;
        inside_vevent = 1'b0;
        line_clear();
    endfunction

    // Characters past the stored value read as zero, so stale entries never leak.
    function automatic bit [7:0] value_at(int p);
        return (p < icse_pkg::DATE_DEPTH && p < value_len) ? value_chars[p] : 8'h00;
    endfunction

    function automatic int leading_number(int pos, int n);
        int       v;
        bit       digits;
        bit [7:0] ch;
        v      = 0;
        digits = 1'b1;
        for (int k = 0; k < n; k++) begin
            ch = value_at(pos + k);
            if (digits && ch >= icse_pkg::CH_ZERO && ch <= icse_pkg::CH_NINE)
                v = v * 10 + (ch - icse_pkg::CH_ZERO);
            else
                digits = 1'b0;
        end
        return v;
    endfunction

    function automatic bit name_matches(icse_pkg::kw_t k);
        string txt;
        txt = keyword_text(k);
        return kw_live[k] && name_len == txt.len();
    endfunction

    function automatic void close_line();
        bit                 vev;
        icse_pkg::dtstart_t d;
        vev = value_vevent && value_len == icse_pkg::VEVENT_LEN;
        if (name_matches(icse_pkg::KW_BEGIN) && vev)
            inside_vevent = 1'b1;
        else if (name_matches(icse_pkg::KW_END) && vev)
            inside_vevent = 1'b0;
        if (inside_vevent && name_matches(icse_pkg::KW_DTSTART)) begin
            d = '0;
            if (value_at(8) == icse_pkg::CH_T && value_at(15) == icse_pkg::CH_Z) begin
                d.year      = 14'(leading_number(0, 4));
                d.month     = 7'(leading_number(4, 2));
                d.day       = 7'(leading_number(6, 2));
                d.hours     = 7'(leading_number(9, 2));
                d.minutes   = 7'(leading_number(11, 2));
                d.seconds   = 7'(leading_number(13, 2));
                d.format_ok = 1'b1;
            end
            dtstart_expected.push_back(d);
        end
    endfunction

    function automatic void predict_beat(bit [7:0] c, bit stream_end);
        bit    copy;
        string txt;
        string vtxt;
        vtxt = "VEVENT";
        // End marker: only a line already closed by CR LF is analysed.
        if (stream_end) begin
            if (fold_phase == icse_pkg::PH_AFTER_CRLF)
                close_line();
            parser_reset();
            return;
        end
        // Byte after CR is taken as LF, whatever it holds.
        if (fold_phase == icse_pkg::PH_AFTER_CR) begin
            fold_phase = icse_pkg::PH_AFTER_CRLF;
            return;
        end
        if (fold_phase == icse_pkg::PH_AFTER_CRLF) begin
            fold_phase = icse_pkg::PH_IN_LINE;
            if (c == icse_pkg::CH_SP)
                return;                 // folded line goes on
            close_line();
            line_clear();
        end
        if (c == icse_pkg::CH_CR) begin
            fold_phase = icse_pkg::PH_AFTER_CR;
            return;
        end
        copy = 1'b1;
        if (c == icse_pkg::CH_QUOTE && !after_bslash) begin
            in_quotes = !in_quotes;
        end else if (!in_quotes && (c == icse_pkg::CH_SEMI || c == icse_pkg::CH_COLON)) begin
            copy = 1'b0;
            if (c == icse_pkg::CH_COLON)
                part = icse_pkg::RG_VALUE;
            else if (part == icse_pkg::RG_NAME)
                part = icse_pkg::RG_PARAM;
        end
        after_bslash = (c == icse_pkg::CH_BSLASH);
        if (copy && part == icse_pkg::RG_NAME) begin
            for (int k = 0; k < icse_pkg::KW_COUNT; k++) begin
                txt = keyword_text(icse_pkg::kw_t'(k));
                if (kw_live[k] && (name_len >= txt.len() || c != txt[name_len]))
                    kw_live[k] = 1'b0;
            end
            if (name_len < icse_pkg::NAME_SAT)
                name_len++;
        end else if (copy && part == icse_pkg::RG_VALUE) begin
            if (value_len < icse_pkg::DATE_DEPTH)
                value_chars[value_len[3:0]] = c;
            if (value_len >= icse_pkg::VEVENT_LEN || c != vtxt[value_len])
                value_vevent = 1'b0;
            if (value_len < icse_pkg::VALUE_SAT)
                value_len++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field compare.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 7);   // start a stall burst
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(string field, logic [13:0] want, logic [13:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        icse_pkg::dtstart_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dtstart_expected.size() == 0) begin
                $display("%0t: result beat, expected none, actual %0d-%0d-%0d ok=%0d",
                         $time, m_year, m_month, m_day, m_format_ok);
                fail_count++;
            end else begin
                want = dtstart_expected.pop_front();
                check_field("year", want.year, m_year);
                check_field("month", 14'(want.month), 14'(m_month));
                check_field("day", 14'(want.day), 14'(m_day));
                check_field("hours", 14'(want.hours), 14'(m_hours));
                check_field("minutes", 14'(want.minutes), 14'(m_minutes));
                check_field("seconds", 14'(want.seconds), 14'(m_seconds));
                check_field("format_ok", 14'(want.format_ok), 14'(m_format_ok));
            end
        end
    end

    // Watchdog: any stretch with no beat on either channel past the limit is a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side. send_beat returns in the step of the accepting edge and
    // leaves s_valid high, so back-to-back beats keep valid unless idle_on adds a gap.
    // ------------------------------------------------------------------
    task automatic send_beat(input bit [7:0] c, input bit stream_end);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_text_byte  <= c;
        s_stream_end <= stream_end;
        do @(posedge aclk); while (!s_ready);
        predict_beat(c, stream_end);
        beats_sent++;
    endtask

    // Optionally folds the text at random points with CR LF SP.
    task automatic send_text(input string txt, input bit fold);
        for (int i = 0; i < txt.len(); i++) begin
            send_beat(txt[i], 1'b0);
            if (fold && i + 1 < txt.len() && $urandom_range(0, 7) == 0) begin
                send_beat(icse_pkg::CH_CR, 1'b0);
                send_beat(CH_LF, 1'b0);
                send_beat(icse_pkg::CH_SP, 1'b0);
            end
        end
    endtask

    // CR, then mostly LF; sometimes an arbitrary byte in the LF slot.
    task automatic end_line();
        bit [7:0] lf;
        lf = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LF;
        send_beat(icse_pkg::CH_CR, 1'b0);
        send_beat(lf, 1'b0);
    endtask

    task automatic send_line(input string txt, input bit fold);
        send_text(txt, fold);
        end_line();
    endtask

    task automatic end_stream();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic string random_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%c", s, $urandom_range(33, 126));
        return s;
    endfunction

    // Well-formed stamp most of the time; otherwise a bad char, a cut or an overrun.
    function automatic string random_stamp();
        string s;
        int    n;
        s = $sformatf("%04d%02d%02dT%02d%02d%02dZ", $urandom_range(0, 9999),
                      $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99),
                      $urandom_range(0, 99), $urandom_range(0, 99));
        n = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: s.putc(n, 8'($urandom_range(32, 126)));
            1: s = s.substr(0, n - 1);
            2: s = {s, random_word($urandom_range(1, 4))};
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_random_line();
        int    pick;
        string txt;
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            // raw noise, any byte value including CR and zero
            repeat ($urandom_range(0, 12)) send_beat(8'($urandom_range(0, 255)), 1'b0);
            end_line();
        end else begin
            if (pick < 12)
                txt = "BEGIN:VEVENT";
            else if (pick < 20)
                txt = "END:VEVENT";
            else if (pick < 55)
                txt = {"DTSTART:", random_stamp()};
            else if (pick < 63)
                txt = {"DTSTART;TZID=\"Zone;A:B\";X=1:", random_stamp()};
            else if (pick < 72) begin
                case ($urandom_range(0, 7))
                    0: txt = "BEGIN:VEVENTS";
                    1: txt = "BEGI:VEVENT";
                    2: txt = "begin:vevent";
                    3: txt = {"DTSTARTS:", random_stamp()};
                    4: txt = {"DTSTAR:", random_stamp()};
                    5: txt = "END;X=\"a:b\":VEVENT";
                    6: txt = {"\"DTSTART\":", random_stamp()};
                    default: txt = {"DTSTART;X=\\\":", random_stamp()};
                endcase
            end else begin
                txt = {"SUMMARY:", random_word($urandom_range(0, 20))};
            end
            if ($urandom_range(0, 19) == 0 && txt.len() > 0)
                txt.putc($urandom_range(0, txt.len() - 1), 8'($urandom_range(1, 255)));
            send_line(txt, $urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 39) == 0)
            end_stream();
    endtask

    // One event with mostly DTSTART lines inside.
    task automatic send_random_event();
        send_line("BEGIN:VEVENT", $urandom_range(0, 7) == 0);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) != 0)
                send_line({"DTSTART:", random_stamp()}, $urandom_range(0, 3) == 0);
            else
                send_random_line();
        end
        send_line("END:VEVENT", $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Keyword handling, date field extremes and malformed values.
    task automatic test_event_lines();
        send_line("DTSTART:20240101T000000Z", 1'b0);        // outside an event
        send_line("BEGIN:VEVENT", 1'b0);
        send_line("DTSTART:99991231T235959Z", 1'b0);
        send_line("DTSTART:00000000T000000Z", 1'b0);
        send_line("DTSTART:20240315T093000", 1'b0);         // no Z
        send_line("DTSTART:2024", 1'b0);                    // short value
        send_line("DTSTART:2x24-3150T9 3000Z", 1'b0);       // digit runs cut short
        send_line("DTSTART:20240315T093000Z12345", 1'b0);   // value saturates
        send_line("DTSTARTXYZ:20240315T093000Z", 1'b0);     // long name
        send_line("DTSTART;TZID=\"A;B:C\":20240315T093000Z", 1'b0);
        send_line("DTSTART;X=\\\":20240101T010203Z", 1'b0); // escaped quote
        send_text("DTSTART:2024", 1'b0);                    // folded value
        send_beat(icse_pkg::CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(icse_pkg::CH_SP, 1'b0);
        send_line("0315T093000Z", 1'b0);
        send_beat(8'h00, 1'b0);                             // zero byte line
        send_beat(8'hFF, 1'b0);
        end_line();
        send_line("END:VEVENT", 1'b0);
        send_line("DTSTART:20240101T000000Z", 1'b0);
    endtask

    // End marker after CR LF, after a bare CR and mid-line.
    task automatic test_stream_end();
        send_line("BEGIN:VEVENT", 1'b0);
        send_line("DTSTART:20250607T080910Z", 1'b0);
        end_stream();                                       // flushes the date
        send_line("DTSTART:20250607T080910Z", 1'b0);        // event state was cleared
        send_line("BEGIN;X=1:VEVENT", 1'b0);
        send_text("DTSTART:20250607T080910Z", 1'b0);
        send_beat(icse_pkg::CH_CR, 1'b0);
        end_stream();                                       // bare CR: dropped
        send_line("BEGIN:VEVENT", 1'b0);
        send_text("DTSTART:2025", 1'b0);
        end_stream();                                       // partial line: dropped
        send_line("BEGIN:VEVENT", 1'b0);
        send_beat(icse_pkg::CH_CR, 1'b0);
        send_beat(8'h41, 1'b0);                             // any byte stands for LF
        send_line("DTSTART:19991231T235959Z", 1'b0);
        end_stream();
    endtask

    task automatic test_random_text();
        int beats_start;
        beats_start = beats_sent;
        while (beats_sent - beats_start < RANDOM_BEATS) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 4) != 0)
                send_random_event();
            else
                send_random_line();
        end
    endtask

    // Back-to-back beats with the result side always ready.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (4) send_random_event();
        end_stream();
    endtask

    initial begin
        parser_reset();
        fail_count    = 0;
        beats_sent    = 0;
        ready_hold    = 0;
        stuck_cycles  = 0;
        idle_on       = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_event_lines();
        test_stream_end();
        test_random_text();
        test_full_rate();

        s_valid <= 1'b0;
        while (dtstart_expected.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/icse_pkg.sv
rtl/icse_dtstart_decode.sv
rtl/icalendar_event_start_extractor_unit.sv
dv/icalendar_event_start_extractor_unit_test.sv
